@@ src/utf8d_pkg.sv @@
// Package for the UTF-8 byte stream decoder.
// Result status codes, result struct and lead byte masks; no dependencies.
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam int CpWidth = 21;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    status_t            status;
  } result_t;

  // lead byte classes: (byte & mask) == pattern
  localparam logic [7:0] AsciiMask  = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Pat   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Pat   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Pat   = 8'hF0;
  localparam logic [7:0] ContMask   = 8'h3F;
  localparam logic [7:0] Lead2Keep  = 8'h1F;
  localparam logic [7:0] Lead3Keep  = 8'h0F;
  localparam logic [7:0] Lead4Keep  = 8'h07;

endpackage

@@ src/utf8d_step.sv @@
// Combinational decode of one byte against the open sequence state.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic [7:0]         byte_in,
  input  logic               end_of_buffer,
  input  logic [1:0]         pending,
  input  logic [CpWidth-1:0] partial,
  output logic [1:0]         pending_next,
  output logic [CpWidth-1:0] partial_next,
  output logic               emit,
  output result_t            result
);

  logic [CpWidth-1:0] shifted;
  logic [1:0]         remaining;
  logic               open_seq;

  assign shifted   = {partial[CpWidth-7:0], byte_in[5:0] & ContMask[5:0]};
  assign remaining = pending - 2'd1;

  always_comb begin
    pending_next      = pending;
    partial_next      = partial;
    emit              = 1'b0;
    open_seq          = 1'b0;
    result.code_point = '0;
    result.status     = ST_OK;

    if (pending == 2'd0) begin
      priority if ((byte_in & AsciiMask) == 8'h00) begin
        emit              = 1'b1;
        result.code_point = {{(CpWidth-8){1'b0}}, byte_in};
      end else if ((byte_in & Lead2Mask) == Lead2Pat) begin
        partial_next = {{(CpWidth-8){1'b0}}, byte_in & Lead2Keep};
        pending_next = 2'd1;
        open_seq     = 1'b1;
      end else if ((byte_in & Lead3Mask) == Lead3Pat) begin
        partial_next = {{(CpWidth-8){1'b0}}, byte_in & Lead3Keep};
        pending_next = 2'd2;
        open_seq     = 1'b1;
      end else if ((byte_in & Lead4Mask) == Lead4Pat) begin
        partial_next = {{(CpWidth-8){1'b0}}, byte_in & Lead4Keep};
        pending_next = 2'd3;
        open_seq     = 1'b1;
      end else begin
        emit          = 1'b1;
        result.status = ST_BAD_LEAD;
      end
    end else begin
      // any byte counts as payload inside a sequence
      pending_next = remaining;
      if (remaining == 2'd0) begin
        emit              = 1'b1;
        result.code_point = shifted;
        partial_next      = '0;
      end else begin
        partial_next = shifted;
        open_seq     = 1'b1;
      end
    end

    // buffer ends mid-sequence
    if (open_seq && end_of_buffer) begin
      emit              = 1'b1;
      result.code_point = '0;
      result.status     = ST_TRUNCATED;
      pending_next      = 2'd0;
      partial_next      = '0;
    end
  end

endmodule

@@ src/utf8d_out_reg.sv @@
// Result register on the master side; loads while empty or being drained.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_data <= load_data;
    end
  end

endmodule

@@ src/utf8_byte_stream_decoder_top.sv @@
// Lenient UTF-8 decoder: one byte per cycle in, at most one code point per byte out.
// A byte request passes the input register, then the result register, before its
// result reaches the master side. Throughput: one byte per cycle, set by the combinational
// decode between the two registers; stalls only under master backpressure.
// Reset (rst, synchronous, active high) empties both registers and closes any sequence.
// Depends on utf8d_pkg, utf8d_step, utf8d_out_reg.
`timescale 1ns / 1ps
module utf8_byte_stream_decoder_top
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_last;
  logic [1:0]         pending;
  logic [CpWidth-1:0] partial;
  logic [1:0]         pending_next;
  logic [CpWidth-1:0] partial_next;
  logic               emit;
  result_t            step_result;
  logic               can_load;
  logic               advance;
  result_t            out_data;

  // input stage moves on whenever the result register can take its outcome
  assign advance       = in_valid && can_load;
  assign s_axis_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= '0;
    end else if (advance) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

  utf8d_step u_step (
    .byte_in       (in_byte),
    .end_of_buffer (in_last),
    .pending       (pending),
    .partial       (partial),
    .pending_next  (pending_next),
    .partial_next  (partial_next),
    .emit          (emit),
    .result        (step_result)
  );

  utf8d_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_data (step_result),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {3'b000, out_data.code_point};
  assign m_axis_tuser = out_data.status;

endmodule

@@ dv/utf8_byte_stream_decoder_top_tb.sv @@
// Self-checking testbench for utf8_byte_stream_decoder_top: a scoreboard class
// predicts each result from the accepted bytes; tasks feed bytes, a loop sets tready.
// Depends on utf8d_pkg and the decoder RTL.
`timescale 1ns / 1ps
module utf8_byte_stream_decoder_top_tb
  import utf8d_pkg::*;
();

  class decode_scoreboard;
    logic [1:0]         bytes_left;
    logic [CpWidth-1:0] gathered;
    result_t            pending_code_points[$];
    int                 mismatches;
    int                 n_bytes;
    int                 n_ok;
    int                 n_bad_lead;
    int                 n_truncated;

    function new();
      bytes_left  = '0;
      gathered    = '0;
      mismatches  = 0;
      n_bytes     = 0;
      n_ok        = 0;
      n_bad_lead  = 0;
      n_truncated = 0;
    endfunction

    // advance the decoder state by one accepted byte request
    function void note_byte(logic [7:0] b, logic last);
      result_t r;
      bit      emitted;
      emitted = 1'b0;
      r       = '0;
      n_bytes++;
      if (bytes_left == 2'd0) begin
        if ((b & AsciiMask) == 8'h00) begin
          r.code_point = CpWidth'(b);
          r.status     = ST_OK;
          emitted      = 1'b1;
        end else if ((b & Lead2Mask) == Lead2Pat) begin
          gathered   = CpWidth'(b & Lead2Keep);
          bytes_left = 2'd1;
        end else if ((b & Lead3Mask) == Lead3Pat) begin
          gathered   = CpWidth'(b & Lead3Keep);
          bytes_left = 2'd2;
        end else if ((b & Lead4Mask) == Lead4Pat) begin
          gathered   = CpWidth'(b & Lead4Keep);
          bytes_left = 2'd3;
        end else begin
          r.status = ST_BAD_LEAD;
          emitted  = 1'b1;
        end
      end else begin
        // any byte counts as payload here, continuation or not
        gathered   = {gathered[CpWidth-7:0], b[5:0]};
        bytes_left = bytes_left - 2'd1;
        if (bytes_left == 2'd0) begin
          r.code_point = gathered;
          r.status     = ST_OK;
          gathered     = '0;
          emitted      = 1'b1;
        end
      end
      if (!emitted && last) begin
        bytes_left = 2'd0;
        gathered   = '0;
        r.status   = ST_TRUNCATED;
        emitted    = 1'b1;
      end
      if (emitted) pending_code_points.push_back(r);
    endfunction

    function void check_result(logic [23:0] tdata, logic [1:0] tuser);
      result_t exp_r;
      if (pending_code_points.size() == 0) begin
        $error("unexpected result: code_point %0h status %0d", tdata[CpWidth-1:0], tuser);
        mismatches++;
        return;
      end
      exp_r = pending_code_points.pop_front();
      case (exp_r.status)
        ST_OK:        n_ok++;
        ST_BAD_LEAD:  n_bad_lead++;
        default:      n_truncated++;
      endcase
      if (tdata[CpWidth-1:0] !== exp_r.code_point) begin
        $error("code_point: expected %0h, actual %0h", exp_r.code_point, tdata[CpWidth-1:0]);
        mismatches++;
      end
      if (tuser !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, tuser);
        mismatches++;
      end
      if (tdata[23:CpWidth] !== '0) begin
        $error("tdata padding: expected 0, actual %0h", tdata[23:CpWidth]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_in
  logic        s_axis_tlast = 1'b0;    // end_of_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [20:0] code_point, [23:21] zero
  logic [1:0]  m_axis_tuser;           // [1:0] status

  decode_scoreboard sb = new();
  int burst_left = 1;
  bit drained_once = 1'b0;

  utf8_byte_stream_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one byte request, then a random gap once the current burst runs out
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_byte(b, last);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_code_points.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed sequences with random payload; some noise and cut-off runs
  task automatic send_random_run();
    int         kind;
    int         len;
    logic [7:0] b;
    logic       last;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      len = $urandom_range(1, 4);
      b = 8'($urandom());
      case (len)
        1:       b = {1'b0, b[6:0]};
        2:       b = {3'b110, b[4:0]};
        3:       b = {4'b1110, b[3:0]};
        default: b = {5'b11110, b[2:0]};
      endcase
      for (int i = 0; i < len; i++) begin
        if (i > 0) begin
          b = 8'($urandom());
          if ($urandom_range(0, 15) != 0) b[7:6] = 2'b10;
        end
        if (i == len - 1) last = ($urandom_range(0, 7) == 0);
        else              last = ($urandom_range(0, 30) == 0);
        push_byte(b, last);
      end
    end else if (kind == 8) begin
      b = 8'($urandom());
      if (b[0]) b = {2'b10, b[6:1]};
      else      b = {5'b11111, b[3:1]};
      push_byte(b, ($urandom_range(0, 3) == 0));
    end else begin
      b = 8'($urandom());
      push_byte(b, ($urandom_range(0, 3) == 0));
    end
  endtask

  // receiver: checks each accepted result; the stall mode is redrawn whenever its counter runs out
  initial begin
    int          mode;
    int          cnt;
    logic [15:0] pattern;
    mode    = 0;
    cnt     = 0;
    pattern = 16'hFFFF;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (cnt == 0) begin
        mode    = $urandom_range(0, 3);
        pattern = 16'($urandom()) | 16'h0001;
        cnt     = 64;
      end
      cnt--;
      pattern = {pattern[14:0], pattern[15]};
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= pattern[0];
      endcase
    end
  end

  initial begin
    logic [7:0] directed_bytes[$];
    logic       directed_last[$];
    // ascii extremes, overlong 2-byte, 3-byte, 4-byte, bad leads,
    // payload that is not a continuation byte, value above the Unicode range,
    // truncated 3-byte, 2-byte completed on the final byte, lone lead on the final byte
    directed_bytes = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hE2, 8'h82, 8'hAC,
                       8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hF8, 8'hFF,
                       8'hC3, 8'h41, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'hE2, 8'h82, 8'hC2, 8'hA9, 8'hF0};
    directed_last  = '{0, 0, 0, 0, 0, 0, 0,
                       0, 0, 0, 0, 0, 0, 0,
                       0, 0, 0, 0, 0, 0,
                       0, 1, 0, 1, 1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_bytes[i]) push_byte(directed_bytes[i], directed_last[i]);
    while (sb.n_bytes < 1800) begin
      send_random_run();
      if (!drained_once && sb.n_bytes >= 900) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
    end
    hold_until_drained();
    repeat (10) @(posedge clk);
    if (sb.pending_code_points.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_code_points.size());
      sb.mismatches++;
    end
    $display("Sent %0d bytes; checked %0d code points, %0d bad leads, %0d truncations.",
             sb.n_bytes, sb.n_ok, sb.n_bad_lead, sb.n_truncated);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout with %0d results outstanding", sb.pending_code_points.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
